>>> rtl/sine_phase_oscillator_defines.svh
// Assertion macros for the sine phase oscillator.
// Clock clk and synchronous reset rst are taken from the module that expands them.
`ifndef SINE_PHASE_OSCILLATOR_DEFINES_SVH
`define SINE_PHASE_OSCILLATOR_DEFINES_SVH

`ifndef SYNTHESIS
`define SPO_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("spo assertion failed");
`define SPO_ASSERT_RST(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("spo reset assertion failed");
`else
`define SPO_ASSERT(label, prop)
`define SPO_ASSERT_RST(label, prop)
`endif

`endif

>>> rtl/spo_pkg.sv
// Shared constants, types and the quarter-wave sine table function.
// No dependencies.
`default_nettype none

package spo_pkg;

  localparam int TABLE_BITS_DEF = 10;
  localparam int PHASE_BITS_DEF = 32;

  localparam int FREQ_W      = 24;
  localparam int SCALE_W     = 32;
  localparam int PROD_W      = FREQ_W + SCALE_W;
  localparam int STEP_TOP    = 47;
  localparam int MAG_W       = 15;
  localparam int SAMPLE_W    = 16;
  localparam int CFG_DATA_W  = 32;
  localparam int CFG_INDEX_W = 2;

  localparam logic [FREQ_W-1:0]  CONST_FREQ_RST = 24'd7040;
  localparam logic [SCALE_W-1:0] HZ_SCALE_RST   = 32'd366503875;

  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [63:0] MAG_MAX     = 64'd32767;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_FREQ_MODE  = 2'd0,
    REG_CONST_FREQ = 2'd1,
    REG_HZ_SCALE   = 2'd2
  } reg_index_t;

  // per-stage load strobes of the pipeline
  typedef struct packed {
    logic s0;
    logic s1;
    logic s2;
    logic s3;
    logic s4;
  } load_t;

  // Q30 Taylor series for sin(k * pi/2 / 2^tb), scaled to 0..32767
  function automatic logic [MAG_W-1:0] quarter_sine(input int unsigned k, input int tb);
    logic [63:0]        x;
    logic [63:0]        x2;
    logic [63:0]        term;
    logic signed [63:0] sum;
    logic [63:0]        v;
    x    = (HALF_PI_Q30 * 64'(k) + ((64'd1 << tb) >> 1)) >> tb;
    x2   = (x * x) >> 30;
    term = x;
    sum  = signed'(x);
    term = ((term * x2) >> 30) / 64'd6;   sum = sum - signed'(term);
    term = ((term * x2) >> 30) / 64'd20;  sum = sum + signed'(term);
    term = ((term * x2) >> 30) / 64'd42;  sum = sum - signed'(term);
    term = ((term * x2) >> 30) / 64'd72;  sum = sum + signed'(term);
    term = ((term * x2) >> 30) / 64'd110; sum = sum - signed'(term);
    term = ((term * x2) >> 30) / 64'd156; sum = sum + signed'(term);
    term = ((term * x2) >> 30) / 64'd210; sum = sum - signed'(term);
    term = ((term * x2) >> 30) / 64'd272; sum = sum + signed'(term);
    term = ((term * x2) >> 30) / 64'd342; sum = sum - signed'(term);
    term = ((term * x2) >> 30) / 64'd420; sum = sum + signed'(term);
    term = ((term * x2) >> 30) / 64'd506; sum = sum - signed'(term);
    if (sum < 0) begin
      return '0;
    end
    v = (unsigned'(sum) * MAG_MAX + (64'd1 << 29)) >> 30;
    if (v > MAG_MAX) begin
      v = MAG_MAX;
    end
    return v[MAG_W-1:0];
  endfunction

endpackage

`default_nettype wire

>>> rtl/spo_step.sv
// Frequency select and phase step multiply: input register, then product register.
// Depends on spo_pkg.
`default_nettype none

module spo_step #(
  parameter int PHASE_BITS = spo_pkg::PHASE_BITS_DEF
) (
  input  wire logic                         clk,
  input  wire spo_pkg::load_t               load,
  input  wire logic                         freq_mode,
  input  wire logic [spo_pkg::FREQ_W-1:0]   const_freq,
  input  wire logic [spo_pkg::SCALE_W-1:0]  hz_scale,
  input  wire logic [spo_pkg::FREQ_W-1:0]   tick_freq,
  output logic      [PHASE_BITS-1:0]        step
);

  logic [spo_pkg::FREQ_W-1:0] freq;
  logic [spo_pkg::PROD_W-1:0] prod;

  always_ff @(posedge clk) begin
    if (load.s0) begin
      freq <= freq_mode ? tick_freq : const_freq;
    end
    if (load.s1) begin
      prod <= spo_pkg::PROD_W'(freq) * spo_pkg::PROD_W'(hz_scale);
    end
  end

  // (freq * scale) >> (48 - PHASE_BITS), low PHASE_BITS bits
  assign step = prod[spo_pkg::STEP_TOP -: PHASE_BITS];

endmodule

`default_nettype wire

>>> rtl/spo_phase.sv
// Phase accumulator and quarter-wave table address fold.
// Depends on spo_pkg.
`default_nettype none

module spo_phase #(
  parameter int TABLE_BITS = spo_pkg::TABLE_BITS_DEF,
  parameter int PHASE_BITS = spo_pkg::PHASE_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire spo_pkg::load_t        load,
  input  wire logic [PHASE_BITS-1:0] step,
  output logic      [TABLE_BITS:0]   addr,
  output logic                       neg
);

  localparam logic [TABLE_BITS:0] QTR = {1'b1, {TABLE_BITS{1'b0}}};

  logic [PHASE_BITS-1:0]   phase_acc;
  logic [TABLE_BITS+1:0]   top;
  logic [1:0]              quad;
  logic [TABLE_BITS-1:0]   idx;

  assign top  = phase_acc[PHASE_BITS-1 -: TABLE_BITS+2];
  assign quad = top[TABLE_BITS+1:TABLE_BITS];
  assign idx  = top[TABLE_BITS-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_acc <= '0;
    end else if (load.s2) begin
      phase_acc <= phase_acc + step;
    end
  end

  // sample uses the phase before this beat's advance
  always_ff @(posedge clk) begin
    if (load.s2) begin
      addr <= quad[0] ? (QTR - {1'b0, idx}) : {1'b0, idx};
      neg  <= quad[1];
    end
  end

endmodule

`default_nettype wire

>>> rtl/spo_sine.sv
// Quarter-wave sine ROM read and sign restore into the output register.
// Depends on spo_pkg.
`default_nettype none

module spo_sine #(
  parameter int TABLE_BITS = spo_pkg::TABLE_BITS_DEF
) (
  input  wire logic                               clk,
  input  wire spo_pkg::load_t                     load,
  input  wire logic        [TABLE_BITS:0]         addr,
  input  wire logic                               neg,
  output logic signed      [spo_pkg::SAMPLE_W-1:0] sample
);

  localparam int N = 1 << TABLE_BITS;

  typedef logic [spo_pkg::MAG_W-1:0] rom_t [0:N];

  function automatic rom_t build_rom();
    rom_t r;
    for (int k = 0; k <= N; k++) begin
      r[k] = spo_pkg::quarter_sine(k, TABLE_BITS);
    end
    return r;
  endfunction

  localparam rom_t ROM = build_rom();

  logic [spo_pkg::MAG_W-1:0] mag;
  logic                      mag_neg;

  always_ff @(posedge clk) begin
    if (load.s3) begin
      mag     <= ROM[addr];
      mag_neg <= neg;
    end
    if (load.s4) begin
      sample <= mag_neg ? -signed'({1'b0, mag}) : signed'({1'b0, mag});
    end
  end

endmodule

`default_nettype wire

>>> rtl/sine_phase_oscillator.sv
// Sine phase oscillator top: config registers, pipeline control, assertions.
// Throughput: one beat per cycle unless sample_stall holds the output, through a
// five-register pipeline (input, product, phase/address, ROM data, output);
// each stage fills its bubbles, and a tick beat's sample comes out of the output register.
// Reset: rst (sync) empties the pipeline, zeroes the phase, restores config defaults.
// Depends on spo_pkg, spo_step, spo_phase, spo_sine, sine_phase_oscillator_defines.svh.
`default_nettype none

`include "sine_phase_oscillator_defines.svh"

module sine_phase_oscillator #(
  parameter int TABLE_BITS = spo_pkg::TABLE_BITS_DEF,
  parameter int PHASE_BITS = spo_pkg::PHASE_BITS_DEF
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 cfg_write_en,
  input  wire logic        [spo_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic        [spo_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  wire logic                                 tick_valid,
  output logic                                      tick_stall,
  input  wire logic        [spo_pkg::FREQ_W-1:0]    tick_freq,
  output logic                                      sample_valid,
  input  wire logic                                 sample_stall,
  output logic signed      [spo_pkg::SAMPLE_W-1:0]  sample
);

  logic                         freq_mode;
  logic [spo_pkg::FREQ_W-1:0]   const_freq;
  logic [spo_pkg::SCALE_W-1:0]  hz_scale;

  logic [4:0]                   stage_valid;
  logic [4:0]                   ready;
  spo_pkg::load_t               load;

  logic [PHASE_BITS-1:0]        step;
  logic [TABLE_BITS:0]          addr;
  logic                         neg;

  always_ff @(posedge clk) begin
    if (rst) begin
      freq_mode  <= 1'b0;
      const_freq <= spo_pkg::CONST_FREQ_RST;
      hz_scale   <= spo_pkg::HZ_SCALE_RST;
    end else if (cfg_write_en) begin
      unique case (cfg_index)
        spo_pkg::REG_FREQ_MODE:  freq_mode  <= cfg_data[0];
        spo_pkg::REG_CONST_FREQ: const_freq <= cfg_data[spo_pkg::FREQ_W-1:0];
        spo_pkg::REG_HZ_SCALE:   hz_scale   <= cfg_data[spo_pkg::SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    ready[4] = !stage_valid[4] || !sample_stall;
    ready[3] = !stage_valid[3] || ready[4];
    ready[2] = !stage_valid[2] || ready[3];
    ready[1] = !stage_valid[1] || ready[2];
    ready[0] = !stage_valid[0] || ready[1];
    load.s0  = tick_valid && ready[0];
    load.s1  = stage_valid[0] && ready[1];
    load.s2  = stage_valid[1] && ready[2];
    load.s3  = stage_valid[2] && ready[3];
    load.s4  = stage_valid[3] && ready[4];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= '0;
    end else begin
      stage_valid[0] <= load.s0 || (stage_valid[0] && !load.s1);
      stage_valid[1] <= load.s1 || (stage_valid[1] && !load.s2);
      stage_valid[2] <= load.s2 || (stage_valid[2] && !load.s3);
      stage_valid[3] <= load.s3 || (stage_valid[3] && !load.s4);
      stage_valid[4] <= load.s4 || (stage_valid[4] && sample_stall);
    end
  end

  assign tick_stall   = !ready[0];
  assign sample_valid = stage_valid[4];

  spo_step #(
    .PHASE_BITS (PHASE_BITS)
  ) u_step (
    .clk        (clk),
    .load       (load),
    .freq_mode  (freq_mode),
    .const_freq (const_freq),
    .hz_scale   (hz_scale),
    .tick_freq  (tick_freq),
    .step       (step)
  );

  spo_phase #(
    .TABLE_BITS (TABLE_BITS),
    .PHASE_BITS (PHASE_BITS)
  ) u_phase (
    .clk  (clk),
    .rst  (rst),
    .load (load),
    .step (step),
    .addr (addr),
    .neg  (neg)
  );

  spo_sine #(
    .TABLE_BITS (TABLE_BITS)
  ) u_sine (
    .clk    (clk),
    .load   (load),
    .addr   (addr),
    .neg    (neg),
    .sample (sample)
  );

  `SPO_ASSERT(a_sample_range, sample_valid |-> sample != {1'b1, {15{1'b0}}})
  `SPO_ASSERT_RST(a_reset_empty, rst |=> !sample_valid)
  `SPO_ASSERT(a_stall_only_full, tick_stall |-> (stage_valid == 5'b11111 && sample_stall))
  `SPO_ASSERT(a_drain, sample_valid && !sample_stall && !stage_valid[3] |=> !sample_valid)

endmodule

`default_nettype wire

>>> test/sine_phase_oscillator_checker.sv
// Checker for the sine phase oscillator: watches the config port and both channels,
// predicts each sample from its own phase accumulator and sine table, compares in order.
// Depends on spo_pkg for port widths, register indexes, reset values and table size.
`timescale 1ns / 1ps

module sine_phase_oscillator_checker (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write_en,
  input  logic [spo_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [spo_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                              tick_valid,
  input  logic                              tick_stall,
  input  logic [spo_pkg::FREQ_W-1:0]        tick_freq,
  input  logic                              sample_valid,
  input  logic                              sample_stall,
  input  logic signed [spo_pkg::SAMPLE_W-1:0] sample,
  output int                                errors,
  output int                                waiting,
  output int                                checked
);

  localparam int TBL_BITS = spo_pkg::TABLE_BITS_DEF;
  localparam int TBL_N = 1 << TBL_BITS;
  localparam logic [63:0] QUARTER_TURN_Q30 = 64'd1686629713;
  localparam logic [63:0] FULL_SCALE = 64'd32767;

  logic [14:0] quarter_wave [0:TBL_N];

  logic                 freq_mode_q;
  logic [23:0]          const_freq_q;
  logic [31:0]          hz_scale_q;
  logic [31:0]          phase;
  logic [55:0]          phase_prod;
  logic signed [15:0]   expected_samples [$];
  logic signed [15:0]   want;
  int                   mismatches = 0;
  int                   n_checked = 0;

  initial begin : build_quarter_wave
    logic [63:0]        x;
    logic [63:0]        x2;
    logic [63:0]        term;
    logic signed [63:0] acc;
    logic [63:0]        v;
    for (int k = 0; k <= TBL_N; k++) begin
      x = (QUARTER_TURN_Q30 * 64'(k) + 64'(TBL_N / 2)) >> TBL_BITS;
      x2 = (x * x) >> 30;
      term = x;
      acc = $signed(x);
      for (int n = 1; n <= 11; n++) begin
        term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
        if (n % 2) begin
          acc = acc - $signed(term);
        end else begin
          acc = acc + $signed(term);
        end
      end
      if (acc < 0) begin
        v = '0;
      end else begin
        v = ($unsigned(acc) * FULL_SCALE + (64'd1 << 29)) >> 30;
      end
      if (v > FULL_SCALE) begin
        v = FULL_SCALE;
      end
      quarter_wave[k] = v[14:0];
    end
  end

  function automatic logic signed [15:0] sine_at(input logic [31:0] ph);
    logic [1:0]         quad;
    logic [9:0]         idx;
    logic signed [15:0] mag;
    quad = ph[31:30];
    idx = ph[29:20];
    mag = quad[0] ? {1'b0, quarter_wave[TBL_N - idx]} : {1'b0, quarter_wave[idx]};
    return quad[1] ? -mag : mag;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      freq_mode_q = 1'b0;
      const_freq_q = spo_pkg::CONST_FREQ_RST;
      hz_scale_q = spo_pkg::HZ_SCALE_RST;
      phase = '0;
      expected_samples.delete();
    end else begin
      if (cfg_write_en) begin
        case (cfg_index)
          spo_pkg::REG_FREQ_MODE:  freq_mode_q = cfg_data[0];
          spo_pkg::REG_CONST_FREQ: const_freq_q = cfg_data[23:0];
          spo_pkg::REG_HZ_SCALE:   hz_scale_q = cfg_data;
          default: ;
        endcase
      end
      if (sample_valid && !sample_stall) begin
        if (expected_samples.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected sample beat: expected none, actual %0d", $time, sample);
        end else begin
          want = expected_samples.pop_front();
          n_checked++;
          if (sample !== want) begin
            mismatches++;
            $display("%0t: sample mismatch: expected %0d, actual %0d", $time, want, sample);
          end
        end
      end
      if (tick_valid && !tick_stall) begin
        expected_samples.push_back(sine_at(phase));
        phase_prod = (freq_mode_q ? tick_freq : const_freq_q) * hz_scale_q;
        phase = phase + phase_prod[47:16];
      end
    end
    errors <= mismatches;
    waiting <= expected_samples.size();
    checked <= n_checked;
  end

endmodule

>>> test/sine_phase_oscillator_test.sv
// Testbench top for the sine phase oscillator: clock, reset, config writes, tick beats
// with random gaps and sample stalls; checking is done by sine_phase_oscillator_checker.
// Depends on spo_pkg, sine_phase_oscillator and sine_phase_oscillator_checker.
`timescale 1ns / 1ps

module sine_phase_oscillator_test;

  localparam int LIMIT = 400000;
  localparam int SEGMENTS = 30;
  localparam int SEG_ITEMS = 65;
  localparam logic [spo_pkg::CFG_INDEX_W-1:0] REG_UNMAPPED = 2'd3;

  logic                               clk = 1'b0;
  logic                               rst = 1'b1;
  logic                               cfg_write_en = 1'b0;
  logic [spo_pkg::CFG_INDEX_W-1:0]    cfg_index = '0;
  logic [spo_pkg::CFG_DATA_W-1:0]     cfg_data = '0;
  logic                               tick_valid = 1'b0;
  logic                               tick_stall;
  logic [spo_pkg::FREQ_W-1:0]         tick_freq = '0;
  logic                               sample_valid;
  logic                               sample_stall = 1'b0;
  logic signed [spo_pkg::SAMPLE_W-1:0] sample;

  int errors;
  int waiting;
  int checked;
  int send_idle_pct = 0;
  int stall_pct = 0;
  int cycle_count = 0;
  int ticks_sent = 0;
  int reg_writes = 0;

  sine_phase_oscillator dut (
    .clk(clk), .rst(rst),
    .cfg_write_en(cfg_write_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .tick_valid(tick_valid), .tick_stall(tick_stall), .tick_freq(tick_freq),
    .sample_valid(sample_valid), .sample_stall(sample_stall), .sample(sample)
  );

  sine_phase_oscillator_checker checker_i (
    .clk(clk), .rst(rst),
    .cfg_write_en(cfg_write_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .tick_valid(tick_valid), .tick_stall(tick_stall), .tick_freq(tick_freq),
    .sample_valid(sample_valid), .sample_stall(sample_stall), .sample(sample),
    .errors(errors), .waiting(waiting), .checked(checked)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    sample_stall <= ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  function automatic logic [spo_pkg::FREQ_W-1:0] pick_freq();
    case ($urandom_range(3))
      0: return spo_pkg::FREQ_W'($urandom_range(255));
      1: return spo_pkg::FREQ_W'($urandom);
      2: return $urandom_range(1) ? '1 : '0;
      default: return spo_pkg::FREQ_W'($urandom_range(320000));
    endcase
  endfunction

  function automatic logic [spo_pkg::SCALE_W-1:0] pick_scale();
    case ($urandom_range(5))
      0: return spo_pkg::HZ_SCALE_RST;
      1: return '1;
      2: return '0;
      3: return $urandom;
      4: return $urandom_range(500000000, 1000000);
      default: return $urandom_range(65535);
    endcase
  endfunction

  // drop valid and wait until every sample has come out
  task automatic settle();
    tick_valid <= 1'b0;
    @(posedge clk);
    while (waiting != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_reg(input logic [spo_pkg::CFG_INDEX_W-1:0] idx,
                           input logic [spo_pkg::CFG_DATA_W-1:0] d);
    cfg_write_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    @(posedge clk);
    cfg_write_en <= 1'b0;
    @(posedge clk);
    reg_writes++;
  endtask

  task automatic send_tick(input logic [spo_pkg::FREQ_W-1:0] f);
    while ($urandom_range(99) < send_idle_pct) begin
      tick_valid <= 1'b0;
      @(posedge clk);
    end
    tick_valid <= 1'b1;
    tick_freq <= f;
    @(posedge clk);
    while (tick_stall) @(posedge clk);
    ticks_sent++;
  endtask

  initial begin
    logic mode;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset defaults, mode 0: tick_freq must be ignored
    send_tick('1);
    send_tick('0);
    send_tick(24'hA5A5A5);
    settle();
    // zero scale holds the phase
    write_reg(spo_pkg::REG_HZ_SCALE, '0);
    send_tick(24'h123456);
    send_tick(24'h000001);
    settle();
    // unmapped index, then full-scale step that wraps
    write_reg(REG_UNMAPPED, '1);
    write_reg(spo_pkg::REG_HZ_SCALE, '1);
    write_reg(spo_pkg::REG_CONST_FREQ, 32'h00FF_FFFF);
    send_tick('0);
    send_tick('0);
    settle();
    // bits above the field width are dropped
    write_reg(spo_pkg::REG_CONST_FREQ, 32'hFF00_0000);
    send_tick('1);
    send_tick('1);
    settle();
    write_reg(spo_pkg::REG_FREQ_MODE, 32'hFFFF_FFFF);
    send_tick('1);
    send_tick('0);
    send_tick(24'h000001);
    repeat (4) send_tick(24'h004000);
    send_tick(24'hAAAAAA);
    send_tick(24'h555555);
    settle();
    write_reg(spo_pkg::REG_FREQ_MODE, 32'hFFFF_FFFE);
    send_tick(24'h00FFFF);
    settle();
    write_reg(spo_pkg::REG_FREQ_MODE, 32'd1);
    write_reg(spo_pkg::REG_HZ_SCALE, spo_pkg::HZ_SCALE_RST);
    send_tick(24'd7040);
    send_tick(24'd7040);
    settle();

    for (int seg = 0; seg < SEGMENTS; seg++) begin
      mode = $urandom_range(1);
      write_reg(spo_pkg::REG_FREQ_MODE, ($urandom & 32'hFFFF_FFFE) | 32'(mode));
      write_reg(spo_pkg::REG_CONST_FREQ, {8'($urandom), pick_freq()});
      write_reg(spo_pkg::REG_HZ_SCALE, pick_scale());
      if ($urandom_range(3) == 0) begin
        write_reg(REG_UNMAPPED, $urandom);
      end
      if (seg < SEGMENTS / 3) begin
        send_idle_pct = 22;
        stall_pct <= 72;
      end else if (seg < 2 * SEGMENTS / 3) begin
        send_idle_pct = 72;
        stall_pct <= 22;
      end else begin
        send_idle_pct = 0;
        stall_pct <= 0;
      end
      for (int i = 0; i < SEG_ITEMS; i++) begin
        send_tick(pick_freq());
      end
      settle();
    end

    stall_pct <= 0;
    repeat (8) @(posedge clk);
    $display("Sent %0d tick beats and checked %0d sample beats over %0d register writes,",
             ticks_sent, checked, reg_writes);
    $display("covering both frequency modes, scale extremes and phase wrap.");
    if (errors == 0 && waiting == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

>>> files.f
+incdir+rtl
rtl/spo_pkg.sv
rtl/spo_step.sv
rtl/spo_phase.sv
rtl/spo_sine.sv
rtl/sine_phase_oscillator.sv
test/sine_phase_oscillator_checker.sv
test/sine_phase_oscillator_test.sv
